// ===== hw/rtl/lmpf_pkg.sv =====
// Shared types and constants of the 3x3 local maximum peak finder.
// Used by lmpf_front, lmpf_queue, lmpf_back and local_max_3x3_peak_finder.
package lmpf_pkg;

   // Line store depth and sample width
   localparam int MAX_COLS   = 2048;
   localparam int PIXEL_BITS = 16;
   localparam int MAX_ROWS   = 4096;

   localparam int COL_BITS   = $clog2(MAX_COLS);
   localparam int ROW_BITS   = 12;
   localparam int FRAME_BITS = 16;
   localparam int COUNT_BITS = 16;

   // Compare widths: wide enough for position plus margin
   localparam int WCMP_BITS  = ((COL_BITS > 12) ? COL_BITS : 12) + 2;
   localparam int RCMP_BITS  = ROW_BITS + 2;

   // Result fields
   localparam int PEAK_ROW_BITS  = 13;
   localparam int PEAK_COL_BITS  = 12;
   localparam int RSP_FIELD_BITS = PEAK_ROW_BITS + PEAK_COL_BITS + FRAME_BITS + COUNT_BITS + 1;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;

   // Result queue between front and back
   localparam int QDEPTH     = 4;
   localparam int QPTR_BITS  = $clog2(QDEPTH);

   // Register file
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_FRAME_COUNT   = 3'd2,
      REG_MIN_LEVEL     = 3'd3,
      REG_PEAK_LIMIT    = 3'd4,
      REG_BORDER_MARGIN = 3'd5
   } reg_index_type;

   typedef enum logic {
      KIND_PEAK    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      logic [11:0]        frame_width;
      logic [12:0]        frame_height;
      logic [15:0]        frame_count;
      logic signed [15:0] min_level;
      logic [15:0]        peak_limit;
      logic [7:0]         border_margin;
   } cfg_type;

   // One queue word: an optional peak followed by an optional summary
   typedef struct packed {
      logic                     has_peak;
      logic [PEAK_ROW_BITS-1:0] peak_row;
      logic [PEAK_COL_BITS-1:0] peak_col;
      logic [FRAME_BITS-1:0]    peak_frame;
      logic                     has_sum;
      logic [COUNT_BITS-1:0]    peaks_found;
      logic                     dropped;
   } rec_type;

endpackage

// ===== hw/rtl/lmpf_front.sv =====
// Front part: accepts pixels, keeps position counters, line store and 3x3 window,
// classifies peaks and counts them per stack. Depends on lmpf_pkg.
module lmpf_front import lmpf_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic signed [PIXEL_BITS-1:0] req_pixel,
   input  logic                         q_full,
   output logic                         q_push,
   output rec_type                      q_rec
);

   // Position counters
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;

   // Effective configuration
   logic [WCMP_BITS-1:0]  fw_x, w_eff, col_x, m_w;
   logic [RCMP_BITS-1:0]  fh_x, h_eff, row_x, m_r;
   logic [FRAME_BITS-1:0] f_eff;
   logic [7:0]            m_eff;

   logic adv, accept, test, col_end, row_end, frame_end, sum_flag;

   // Stage 1 (line store read data valid)
   logic                         s1_valid_ff;
   logic signed [PIXEL_BITS-1:0] s1_px_ff;
   logic [COL_BITS-1:0]          s1_col_ff;
   logic [ROW_BITS-1:0]          s1_row_ff;
   logic [FRAME_BITS-1:0]        s1_frame_ff;
   logic                         s1_test_ff;
   logic                         s1_sum_ff;
   logic [2*PIXEL_BITS-1:0]      rd_ff;
   logic [2*PIXEL_BITS-1:0]      line_mem [MAX_COLS];

   logic signed [PIXEL_BITS-1:0] up1, up2;
   logic signed [PIXEL_BITS-1:0] win_ff [9];
   logic signed [PIXEL_BITS-1:0] win_in [9];
   logic                         is_max;

   // Stage 2 (classified)
   logic                  s2_valid_ff;
   logic                  s2_peak_ff;
   logic [ROW_BITS-1:0]   s2_row_ff;
   logic [COL_BITS-1:0]   s2_col_ff;
   logic [FRAME_BITS-1:0] s2_frame_ff;
   logic                  s2_sum_ff;

   // Stack statistics
   logic [COUNT_BITS-1:0] total_ff, total_in, total_next;
   logic                  drop_ff, drop_in, drop_next;
   logic                  emit;

   assign adv        = !(s2_valid_ff && q_full);
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   always_comb begin
      fw_x = WCMP_BITS'(cfg.frame_width);
      if (fw_x < WCMP_BITS'(3)) begin
         w_eff = WCMP_BITS'(3);
      end else if (fw_x > WCMP_BITS'(MAX_COLS)) begin
         w_eff = WCMP_BITS'(MAX_COLS);
      end else begin
         w_eff = fw_x;
      end
      fh_x = RCMP_BITS'(cfg.frame_height);
      if (fh_x < RCMP_BITS'(3)) begin
         h_eff = RCMP_BITS'(3);
      end else if (fh_x > RCMP_BITS'(MAX_ROWS)) begin
         h_eff = RCMP_BITS'(MAX_ROWS);
      end else begin
         h_eff = fh_x;
      end
      f_eff = (cfg.frame_count == '0) ? FRAME_BITS'(1) : cfg.frame_count;
      m_eff = (cfg.border_margin == '0) ? 8'd1 : cfg.border_margin;
   end

   // Centre (r-1, c-1) tested when r > m, r + m <= h, same for columns
   always_comb begin
      col_x     = WCMP_BITS'(col_ff);
      row_x     = RCMP_BITS'(row_ff);
      m_w       = WCMP_BITS'(m_eff);
      m_r       = RCMP_BITS'(m_eff);
      test      = (col_x > m_w) && ((col_x + m_w) <= w_eff) &&
                  (row_x > m_r) && ((row_x + m_r) <= h_eff);
      col_end   = (col_x + WCMP_BITS'(1)) >= w_eff;
      row_end   = (row_x + RCMP_BITS'(1)) >= h_eff;
      frame_end = ({1'b0, frame_ff} + 17'd1) >= {1'b0, f_eff};
      sum_flag  = col_end && row_end && frame_end;
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      frame_in = frame_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in = '0;
               if (frame_end) begin
                  frame_in = '0;
               end else begin
                  frame_in = frame_ff + FRAME_BITS'(1);
               end
            end else begin
               row_in = row_ff + ROW_BITS'(1);
            end
         end else begin
            col_in = col_ff + COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         frame_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         frame_ff <= frame_in;
      end
   end

   // Line store: entry holds {row before previous, previous row}
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (adv && s1_valid_ff) begin
         line_mem[s1_col_ff] <= {up1, s1_px_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= req_pixel;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_frame_ff <= frame_ff + FRAME_BITS'(1);
         s1_test_ff  <= test;
         s1_sum_ff   <= sum_flag;
      end
   end

   assign up1 = $signed(rd_ff[PIXEL_BITS-1:0]);
   assign up2 = $signed(rd_ff[2*PIXEL_BITS-1:PIXEL_BITS]);

   // Shift the window one column and test the centre
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3]     = win_ff[k*3+1];
         win_in[k*3 + 1] = win_ff[k*3+2];
      end
      win_in[2] = up2;
      win_in[5] = up1;
      win_in[8] = s1_px_ff;
      is_max = (win_in[4] >= cfg.min_level);
      for (int k = 0; k < 9; k++) begin
         if (k != 4 && win_in[k] >= win_in[4]) begin
            is_max = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         win_ff      <= win_in;
         s2_peak_ff  <= s1_test_ff && is_max;
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_frame_ff <= s1_frame_ff;
         s2_sum_ff   <= s1_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Count reported peaks, flag the ones past the limit
   always_comb begin
      emit       = s2_peak_ff && (total_ff < cfg.peak_limit);
      total_next = total_ff + COUNT_BITS'(emit);
      drop_next  = drop_ff || (s2_peak_ff && !emit);
      total_in   = total_ff;
      drop_in    = drop_ff;
      if (adv && s2_valid_ff) begin
         total_in = s2_sum_ff ? '0 : total_next;
         drop_in  = s2_sum_ff ? 1'b0 : drop_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         total_ff <= total_in;
         drop_ff  <= drop_in;
      end
   end

   assign q_push = adv && s2_valid_ff && (emit || s2_sum_ff);

   always_comb begin
      q_rec.has_peak    = emit;
      q_rec.peak_row    = PEAK_ROW_BITS'(s2_row_ff);
      q_rec.peak_col    = PEAK_COL_BITS'(s2_col_ff);
      q_rec.peak_frame  = s2_frame_ff;
      q_rec.has_sum     = s2_sum_ff;
      q_rec.peaks_found = total_next;
      q_rec.dropped     = drop_next;
   end

endmodule

// ===== hw/rtl/lmpf_queue.sv =====
// Short result queue between front and back of the peak finder.
// Depends on lmpf_pkg for the queue word type and depth.
module lmpf_queue import lmpf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output rec_type head_rec,
   output logic    empty,
   output logic    full
);

   rec_type              entry_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (QPTR_BITS+1)'(QDEPTH));
   assign head_rec = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/lmpf_back.sv =====
// Back part: splits each queue word into peak and summary results and
// drives the registered result channel. Depends on lmpf_pkg.
module lmpf_back import lmpf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  rec_type                   head_rec,
   input  logic                      q_empty,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,  // row, col, frame, peaks_found, dropped
   output logic                      rsp_tuser,  // kind
   output logic                      rsp_tlast
);

   logic                      out_valid_ff, out_valid_in;
   logic [RSP_TDATA_BITS-1:0] out_data_ff, out_data_in;
   kind_type                  out_kind_ff, out_kind_in;
   logic                      out_last_ff, out_last_in;
   logic                      peak_sent_ff, peak_sent_in;
   logic                      load, send_peak;

   assign load      = !q_empty && (!out_valid_ff || rsp_tready);
   assign send_peak = head_rec.has_peak && !peak_sent_ff;

   always_comb begin
      if (send_peak) begin
         out_data_in  = RSP_TDATA_BITS'({17'd0, head_rec.peak_frame,
                                         head_rec.peak_col, head_rec.peak_row});
         out_kind_in  = KIND_PEAK;
         out_last_in  = !head_rec.has_sum;
         q_pop        = load && !head_rec.has_sum;
         peak_sent_in = load ? head_rec.has_sum : peak_sent_ff;
      end else begin
         out_data_in  = RSP_TDATA_BITS'({head_rec.dropped, head_rec.peaks_found,
                                         (PEAK_ROW_BITS+PEAK_COL_BITS+FRAME_BITS)'(0)});
         out_kind_in  = KIND_SUMMARY;
         out_last_in  = 1'b1;
         q_pop        = load;
         peak_sent_in = load ? 1'b0 : peak_sent_ff;
      end
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         peak_sent_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         peak_sent_ff <= peak_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= out_data_in;
         out_kind_ff <= out_kind_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hw/rtl/local_max_3x3_peak_finder.sv =====
// Top level of the 3x3 local maximum peak finder: register file, front, queue, back.
// Depends on lmpf_pkg, lmpf_front, lmpf_queue and lmpf_back.
//
// Usage: stream a stack of frames one pixel word per cycle on req_ in raster
// order (columns fastest, then rows, then frames). Each pixel that completes a
// 3x3 neighbourhood whose centre is a strict local maximum at or above
// min_level, and at least border_margin away from each edge, yields a peak
// word on rsp_ (tuser = 0) with 1-based row, column and frame. The last pixel
// of a stack also yields a summary word (tuser = 1) with the peak count and
// the dropped flag; tlast marks the final word that one pixel causes.
// Throughput: one pixel per cycle while req_tready is high, set by the line store,
// which takes one read on accept and one write, at another column, as the pixel
// leaves the read stage. A pixel that causes a peak and a summary needs two result
// words; the four-word queue absorbs that. A result passes the line store read,
// window and compare, peak count and queue push, and the output register before it is shown.
// When the receiver stalls, the output register holds and the
// queue fills; once it is full and the count stage holds a pixel, whether or
// not that pixel has a word to push, req_tready drops.
// Reset clears counters, queue and output register and loads the default
// registers; the line store is not cleared, since the first two rows of a
// frame are never tested. Write registers only while the block is idle.
module local_max_3x3_peak_finder import lmpf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // pixel stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // pixel
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // peak_row, peak_col, peak_frame,
                                                  // peaks_found, dropped
   output logic                      rsp_tuser,   // kind
   output logic                      rsp_tlast,
   // register write port
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg_ff;
   rec_type push_rec, head_rec;
   logic    q_push, q_pop, q_empty, q_full;

   // Register file: write-only, takes effect on the next pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= 12'd2048;
         cfg_ff.frame_height  <= 13'd2048;
         cfg_ff.frame_count   <= 16'd1;
         cfg_ff.min_level     <= 16'sd0;
         cfg_ff.peak_limit    <= 16'hFFFF;
         cfg_ff.border_margin <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_FRAME_WIDTH:   cfg_ff.frame_width   <= csr_wdata[11:0];
            REG_FRAME_HEIGHT:  cfg_ff.frame_height  <= csr_wdata[12:0];
            REG_FRAME_COUNT:   cfg_ff.frame_count   <= csr_wdata;
            REG_MIN_LEVEL:     cfg_ff.min_level     <= $signed(csr_wdata);
            REG_PEAK_LIMIT:    cfg_ff.peak_limit    <= csr_wdata;
            REG_BORDER_MARGIN: cfg_ff.border_margin <= csr_wdata[7:0];
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // Front: accept, window, classify, count
   lmpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_pixel  ($signed(req_tdata[PIXEL_BITS-1:0])),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_rec      (push_rec)
   );

   // Queue: decouple front stalls from receiver stalls
   lmpf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (push_rec),
      .pop      (q_pop),
      .head_rec (head_rec),
      .empty    (q_empty),
      .full     (q_full)
   );

   // Back: serialize peak and summary words
   lmpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_rec   (head_rec),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue pop while empty");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> q_full)
      else $error("input stalled with room in queue");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SUMMARY) |-> rsp_tlast)
      else $error("summary word without tlast");

endmodule

// ===== bench/tb_local_max_3x3_peak_finder.sv =====
// Self-checking bench for local_max_3x3_peak_finder: directed frames, then random stacks.
// Streams pixel words under several idle/stall mixes and checks every result word against
// its own peak predictor. Depends on lmpf_pkg and the local_max_3x3_peak_finder RTL.
module tb_local_max_3x3_peak_finder;
   import lmpf_pkg::*;

   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int LATENCY_PAD     = 8;     // pipeline depth plus queue, rounded up
   localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
   localparam int ITEMS_PER_PHASE = 380;

   // rsp_tdata field offsets, lowest field first
   localparam int ROW_LSB   = 0;
   localparam int COL_LSB   = ROW_LSB + PEAK_ROW_BITS;
   localparam int FRAME_LSB = COL_LSB + PEAK_COL_BITS;
   localparam int FOUND_LSB = FRAME_LSB + FRAME_BITS;
   localparam int DROP_LSB  = FOUND_LSB + COUNT_BITS;

   typedef enum int {FILL_RANDOM, FILL_TIES, FILL_SPARSE, FILL_EXTREME} fill_mode_type;

   // One result word as the block should present it
   typedef struct packed {
      kind_type                 kind;
      logic [PEAK_ROW_BITS-1:0] row;
      logic [PEAK_COL_BITS-1:0] col;
      logic [FRAME_BITS-1:0]    frame;
      logic [COUNT_BITS-1:0]    found;
      logic                     dropped;
      logic                     last;
   } peak_word_type;

   // Directed stimulus row: either a register setup or one pixel word.
   // typed_n < 0 means the predictor supplies the expected words.
   typedef struct {
      bit                    is_setup;
      cfg_type               setup;
      logic [PIXEL_BITS-1:0] pixel;
      int                    typed_n;
      peak_word_type         typed [2];
   } plan_row_type;

   // DUT connections; every input starts at a known value
   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;    // pixel
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;          // peak_row, peak_col, peak_frame,
                                                  // peaks_found, dropped
   logic                      rsp_tuser;          // kind
   logic                      rsp_tlast;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // Predictor state: register copy, two line stores, 3x3 window, raster counters
   cfg_type shadow = '{frame_width: 12'd2048, frame_height: 13'd2048, frame_count: 16'd1,
                       min_level: 16'sd0, peak_limit: 16'hFFFF, border_margin: 8'd1};
   logic signed [PIXEL_BITS-1:0] row_prev  [MAX_COLS];
   logic signed [PIXEL_BITS-1:0] row_prev2 [MAX_COLS];
   logic signed [PIXEL_BITS-1:0] win [9];
   logic [COL_BITS-1:0]          col_pos;
   logic [ROW_BITS-1:0]          row_pos;
   logic [FRAME_BITS-1:0]        frame_pos;
   logic [COUNT_BITS-1:0]        peak_total;
   logic                         drop_flag;

   peak_word_type peaks_due [$];  // expected result words, oldest first
   int mismatches      = 0;
   int cycle_count     = 0;
   int sender_idle_pct = 0;
   int rx_stall_pct    = 0;
   int hold_asked      = 0;       // bumped by the stimulus to request a long hold-off
   int hold_served     = 0;
   int hold_left       = 0;

   local_max_3x3_peak_finder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int unsigned clamp_u(input int unsigned v, lo, hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic peak_word_type make_word(input kind_type kind, input int row, col,
                                               frame, input int found,
                                               input bit dropped, last);
      peak_word_type w;
      w.kind    = kind;
      w.row     = PEAK_ROW_BITS'(row);
      w.col     = PEAK_COL_BITS'(col);
      w.frame   = FRAME_BITS'(frame);
      w.found   = COUNT_BITS'(found);
      w.dropped = dropped;
      w.last    = last;
      return w;
   endfunction

   function automatic cfg_type make_cfg(input int width, height, count, level, limit, margin);
      cfg_type c;
      c.frame_width   = 12'(width);
      c.frame_height  = 13'(height);
      c.frame_count   = 16'(count);
      c.min_level     = 16'(level);
      c.peak_limit    = 16'(limit);
      c.border_margin = 8'(margin);
      return c;
   endfunction

   function automatic plan_row_type setup_row(input cfg_type c);
      plan_row_type p;
      p.is_setup = 1'b1;
      p.setup    = c;
      p.pixel    = '0;
      p.typed_n  = -1;
      return p;
   endfunction

   function automatic plan_row_type pixel_row(input logic [PIXEL_BITS-1:0] px,
                                              input int n = -1,
                                              input peak_word_type w0 = '0,
                                              input peak_word_type w1 = '0);
      plan_row_type p;
      p.is_setup = 1'b0;
      p.setup    = shadow;
      p.pixel    = px;
      p.typed_n  = n;
      p.typed[0] = w0;
      p.typed[1] = w1;
      return p;
   endfunction

   // Advance the predictor by one accepted pixel; queue its words when keep is set.
   function automatic void predict_peaks(input logic [PIXEL_BITS-1:0] px, input bit keep);
      int unsigned w, h, f, m, c, r, cr, cc;
      int k;
      logic signed [PIXEL_BITS-1:0] up1, up2, ctr;
      bit is_peak;
      peak_word_type made [$];
      w = clamp_u(shadow.frame_width, 3, MAX_COLS);
      h = clamp_u(shadow.frame_height, 3, MAX_ROWS);
      f = (shadow.frame_count == 0) ? 1 : shadow.frame_count;
      m = (shadow.border_margin == 0) ? 1 : shadow.border_margin;
      c = col_pos;
      r = row_pos;
      up1 = row_prev[c];
      up2 = row_prev2[c];

      // shift the window left, new column enters on the right
      for (k = 0; k < 3; k++) begin
         win[3*k]   = win[3*k+1];
         win[3*k+1] = win[3*k+2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = px;
      row_prev2[c] = up1;
      row_prev[c]  = px;

      // centre sits one row up and one column left of the incoming pixel
      if (r >= 2 && c >= 2) begin
         cr = r - 1;
         cc = c - 1;
         if (cr >= m && cr + m < h && cc >= m && cc + m < w) begin
            ctr     = win[4];
            is_peak = (ctr >= $signed(shadow.min_level));
            for (k = 0; k < 9; k++)
               if (k != 4 && win[k] >= ctr) is_peak = 1'b0;
            if (is_peak) begin
               if (peak_total < shadow.peak_limit) begin
                  made.push_back(make_word(KIND_PEAK, cr + 1, cc + 1, frame_pos + 1, 0, 0, 0));
                  peak_total = peak_total + 1'b1;
               end else begin
                  drop_flag = 1'b1;
               end
            end
         end
      end

      // raster counters; the last pixel of the stack emits the summary and clears
      if (c + 1 >= w) begin
         col_pos = '0;
         if (r + 1 >= h) begin
            row_pos = '0;
            if (frame_pos + 1 >= f) begin
               made.push_back(make_word(KIND_SUMMARY, 0, 0, 0, peak_total, drop_flag, 0));
               frame_pos  = '0;
               peak_total = '0;
               drop_flag  = 1'b0;
            end else begin
               frame_pos = frame_pos + 1'b1;
            end
         end else begin
            row_pos = ROW_BITS'(r + 1);
         end
      end else begin
         col_pos = COL_BITS'(c + 1);
      end

      if (made.size() > 0) made[made.size()-1].last = 1'b1;
      if (keep) foreach (made[i]) peaks_due.push_back(made[i]);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] make_pixel(input fill_mode_type mode);
      logic [PIXEL_BITS-1:0] px;
      case (mode)
         FILL_RANDOM: px = PIXEL_BITS'($urandom());
         FILL_TIES:   px = PIXEL_BITS'($urandom_range(3));
         FILL_SPARSE: px = ($urandom_range(5) == 0) ? PIXEL_BITS'($urandom_range(32767, 100))
                                                     : PIXEL_BITS'($urandom_range(20));
         default: begin
            case ($urandom_range(3))
               0:       px = 16'h8000;
               1:       px = 16'h7FFF;
               2:       px = 16'hFFFF;
               default: px = PIXEL_BITS'($urandom());
            endcase
         end
      endcase
      return px;
   endfunction

   // Small random frames; now and then a size that clamps, a margin that blocks every
   // centre, a zero frame count or a tight peak limit.
   function automatic cfg_type random_setup();
      cfg_type c;
      c.frame_width  = ($urandom_range(9) == 0) ? 12'($urandom_range(2))
                                                : 12'($urandom_range(9, 3));
      c.frame_height = ($urandom_range(9) == 0) ? 13'($urandom_range(2))
                                                : 13'($urandom_range(7, 3));
      c.frame_count  = 16'($urandom_range(3));
      case ($urandom_range(3))
         0:       c.min_level = 16'h8000;
         1:       c.min_level = '0;
         2:       c.min_level = 16'($urandom_range(8));
         default: c.min_level = 16'($urandom());
      endcase
      c.peak_limit    = ($urandom_range(2) != 0) ? 16'hFFFF : 16'($urandom_range(4));
      c.border_margin = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(3));
      return c;
   endfunction

   // Offer one pixel word, with random idle cycles first; return at the accepting edge.
   task automatic send_word(input logic [PIXEL_BITS-1:0] px);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'(px);
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid, wait out every expected word, then let the pipeline settle.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (peaks_due.size() != 0) @(posedge clock);
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   // Hold the write enable across back-to-back writes; the caller lowers it.
   task automatic put_reg(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic load_setup(input cfg_type c);
      put_reg(REG_FRAME_WIDTH,   CSR_DATA_BITS'(c.frame_width));
      put_reg(REG_FRAME_HEIGHT,  CSR_DATA_BITS'(c.frame_height));
      put_reg(REG_FRAME_COUNT,   CSR_DATA_BITS'(c.frame_count));
      put_reg(REG_MIN_LEVEL,     CSR_DATA_BITS'(c.min_level));
      put_reg(REG_PEAK_LIMIT,    CSR_DATA_BITS'(c.peak_limit));
      put_reg(REG_BORDER_MARGIN, CSR_DATA_BITS'(c.border_margin));
      csr_we <= 1'b0;
      shadow = c;
   endtask

   // Drain, program a setup, optionally start a long hold-off, then stream frames.
   task automatic run_stack(input cfg_type c, input int frames, input fill_mode_type mode,
                            input bit hold_rx, inout int items);
      int unsigned total;
      int unsigned n;
      logic [PIXEL_BITS-1:0] px;
      wait_drained();
      load_setup(c);
      if (hold_rx) hold_asked++;
      total = clamp_u(c.frame_width, 3, MAX_COLS) * clamp_u(c.frame_height, 3, MAX_ROWS)
              * frames;
      for (n = 0; n < total; n++) begin
         px = make_pixel(mode);
         send_word(px);
         predict_peaks(px, 1'b1);
      end
      items += total;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Receiver: random stalls, or a long hold-off counted here when one is requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served = hold_served + 1;
         hold_left   = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Check each accepted result word against the oldest expectation
   always @(posedge clock) begin
      peak_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (peaks_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, got tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = peaks_due.pop_front();
            check_field("kind",        want.kind,    rsp_tuser);
            check_field("peak_row",    want.row,     rsp_tdata[ROW_LSB +: PEAK_ROW_BITS]);
            check_field("peak_col",    want.col,     rsp_tdata[COL_LSB +: PEAK_COL_BITS]);
            check_field("peak_frame",  want.frame,   rsp_tdata[FRAME_LSB +: FRAME_BITS]);
            check_field("peaks_found", want.found,   rsp_tdata[FOUND_LSB +: COUNT_BITS]);
            check_field("dropped",     want.dropped, rsp_tdata[DROP_LSB]);
            check_field("last",        want.last,    rsp_tlast);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** local_max_3x3_peak_finder: FAILED **");
         $finish;
      end
   end

   initial begin
      plan_row_type plan [$];
      cfg_type      setup;
      int           items;
      int           phase;
      int           k;

      foreach (row_prev[i]) begin
         row_prev[i]  = '0;
         row_prev2[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_pos    = '0;
      row_pos    = '0;
      frame_pos  = '0;
      peak_total = '0;
      drop_flag  = 1'b0;
      items      = 0;

      // Directed plan, three 3x3 stacks. A zero margin acts as one, so only the
      // centre is tested. First: a lone 5 in a field of zeros is a peak.
      plan.push_back(setup_row(make_cfg(3, 3, 1, 0, 65535, 0)));
      for (k = 0; k < 8; k++) plan.push_back(pixel_row((k == 4) ? 16'd5 : 16'd0));
      plan.push_back(pixel_row(16'd0, 2, make_word(KIND_PEAK, 2, 2, 1, 0, 0, 0),
                                         make_word(KIND_SUMMARY, 0, 0, 0, 1, 0, 1)));
      // Full-scale centre meets the highest level, but a zero limit drops it
      plan.push_back(setup_row(make_cfg(3, 3, 1, 32767, 0, 1)));
      for (k = 0; k < 8; k++) plan.push_back(pixel_row((k == 4) ? 16'h7FFF : 16'h8000));
      plan.push_back(pixel_row(16'h8000, 1, make_word(KIND_SUMMARY, 0, 0, 0, 0, 1, 1)));
      // A flat frame: equal neighbours never make a peak
      plan.push_back(setup_row(make_cfg(3, 3, 1, -32768, 65535, 1)));
      for (k = 0; k < 8; k++) plan.push_back(pixel_row(16'd1));
      plan.push_back(pixel_row(16'd1, 1, make_word(KIND_SUMMARY, 0, 0, 0, 0, 0, 1)));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the plan; typed rows still advance the predictor but use the typed words
      foreach (plan[i]) begin
         if (plan[i].is_setup) begin
            wait_drained();
            load_setup(plan[i].setup);
         end else begin
            send_word(plan[i].pixel);
            predict_peaks(plan[i].pixel, plan[i].typed_n < 0);
            for (k = 0; k < plan[i].typed_n; k++) peaks_due.push_back(plan[i].typed[k]);
         end
      end

      // Sizes that clamp up to three, and margins that block every row or column
      run_stack(make_cfg(0, 1, 1, -32768, 65535, 1), 1, FILL_RANDOM, 1'b0, items);
      run_stack(make_cfg(9, 2, 1, 0, 65535, 3), 1, FILL_SPARSE, 1'b0, items);
      run_stack(make_cfg(2, 7, 1, -32768, 65535, 2), 1, FILL_EXTREME, 1'b0, items);
      // Start a very long stack, then cut it short: frame count zero acts as one, so the
      // next frame closes it and the count and drop flag carry over
      run_stack(make_cfg(5, 5, 65535, -32768, 3, 1), 2, FILL_RANDOM, 1'b0, items);
      run_stack(make_cfg(5, 5, 0, -32768, 3, 1), 1, FILL_RANDOM, 1'b0, items);
      // Margin wider than the frame: no centre is ever tested
      run_stack(make_cfg(6, 6, 1, -32768, 65535, 255), 1, FILL_RANDOM, 1'b0, items);

      // Random stacks under four idle/stall mixes
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin sender_idle_pct = 88; rx_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  rx_stall_pct = 88; end
            default: begin sender_idle_pct = 25; rx_stall_pct = 25; end
         endcase
         items = 0;
         // Peak-rich stack behind a long hold-off: the queue fills and req_tready drops
         if (phase == 0)
            run_stack(make_cfg(8, 6, 10, -32768, 65535, 1), 10, FILL_RANDOM, 1'b1, items);
         while (items < ITEMS_PER_PHASE) begin
            setup = random_setup();
            run_stack(setup, (setup.frame_count == 0) ? 1 : int'(setup.frame_count),
                      fill_mode_type'($urandom_range(3)), 1'b0, items);
         end
      end

      wait_drained();
      if (mismatches == 0)
         $display("** local_max_3x3_peak_finder: PASSED **");
      else
         $display("** local_max_3x3_peak_finder: FAILED **");
      $finish;
   end

endmodule

// ===== local_max_3x3_peak_finder.f =====
hw/rtl/lmpf_pkg.sv
hw/rtl/lmpf_front.sv
hw/rtl/lmpf_queue.sv
hw/rtl/lmpf_back.sv
hw/rtl/local_max_3x3_peak_finder.sv
bench/tb_local_max_3x3_peak_finder.sv
